>>> design/crr_pkg.sv
// shared types and widths for the circumcircle radius pipeline
`default_nettype none
package crr_pkg;

  localparam int IN_W        = 19;   // one coordinate, signed
  localparam int DIF_W       = 21;   // twice a coordinate difference
  localparam int PSQ_W       = 38;   // square of one coordinate
  localparam int SQ_W        = 39;   // sum and difference of squares
  localparam int DET_W       = 43;   // determinant, signed
  localparam int DEN_W       = 42;   // determinant magnitude
  localparam int NUM_W       = 60;   // centre numerators, signed, and their magnitudes
  localparam int CX_W        = 61;   // signed centre coordinate
  localparam int DX_W        = 62;   // centre minus first point
  localparam int RAD_W       = 21;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 24;

  typedef logic signed [IN_W-1:0] coord_t;

  // travels alongside the two quotients through the divider
  typedef struct packed {
    coord_t x1;
    coord_t y1;
    logic   neg_x;
    logic   neg_y;
    logic   deg;
  } div_tag_t;

  // travels alongside the root through the square root unit
  typedef struct packed {
    logic far;
    logic deg;
    logic cright;
  } sq_tag_t;

endpackage
`default_nettype wire

>>> design/circumcircle_radius_top.sv
// circumcircle radius of three planar points, fully pipelined
//
// in channel: one transaction carries three points, each coordinate signed
// 19-bit fixed point with FRAC_BITS fraction bits. out channel: one transaction
// per input carrying the radius (clamped to 1..5000 m, 21 bits), whether the
// centre lies at positive x, and in tuser a flag for collinear points, which
// give radius 5000 m and centre_right low.
// RW, the stage count of the square root, is (2*ceil(log2(5000*2^FRAC_BITS+1)) + 2) / 2.
// five front stages form the determinant and numerators, a 60-stage divider
// gives both centre coordinates, five stages form the squared distance and an
// RW-stage square root gives the radius; a final output register holds it.
// throughput is one transaction per cycle while the output is taken.
// all stages advance together: when the output holds a result that is not
// taken, the whole pipeline holds and in_tready drops; nothing is lost.
// reset clears all valid bits; the pipeline comes out of reset empty.
`default_nettype none
module circumcircle_radius_top #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y, zero fill
  input  wire logic [crr_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // radius, center_right, zero fill
  output logic [crr_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // degenerate
  output logic [0:0]                           out_tuser
);
  import crr_pkg::*;

  localparam int RMAX     = 5000 << FRAC_BITS;
  localparam int RMIN     = 1 << FRAC_BITS;
  localparam int LIM_W    = $clog2(RMAX + 1);
  localparam int SUM_W    = 2 * LIM_W + 1;
  localparam int SW       = SUM_W + (SUM_W % 2);
  localparam int RT_W     = SW / 2;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: differences and squares
  coord_t px1, py1, px2, py2, px3, py3;
  assign px1 = in_tdata[18:0];
  assign py1 = in_tdata[37:19];
  assign px2 = in_tdata[56:38];
  assign py2 = in_tdata[75:57];
  assign px3 = in_tdata[94:76];
  assign py3 = in_tdata[113:95];

  logic signed [DIF_W-2:0] da_nxt, db_nxt, dd_nxt, de_nxt;
  assign da_nxt = (DIF_W-1)'(px2) - (DIF_W-1)'(px1);
  assign db_nxt = (DIF_W-1)'(py2) - (DIF_W-1)'(py1);
  assign dd_nxt = (DIF_W-1)'(px3) - (DIF_W-1)'(px2);
  assign de_nxt = (DIF_W-1)'(py3) - (DIF_W-1)'(py2);

  logic                    v1_r;
  logic signed [DIF_W-1:0] a1_r, b1_r, d1_r, e1_r;
  logic signed [PSQ_W-1:0] sx1_r, sy1_r, sx2_r, sy2_r, sx3_r, sy3_r;
  coord_t                  x1_1_r, y1_1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= {da_nxt, 1'b0};
      b1_r   <= {db_nxt, 1'b0};
      d1_r   <= {dd_nxt, 1'b0};
      e1_r   <= {de_nxt, 1'b0};
      sx1_r  <= px1 * px1;
      sy1_r  <= py1 * py1;
      sx2_r  <= px2 * px2;
      sy2_r  <= py2 * py2;
      sx3_r  <= px3 * px3;
      sy3_r  <= py3 * py3;
      x1_1_r <= px1;
      y1_1_r <= py1;
    end
  end

  // stage 2: c and f
  logic signed [SQ_W-1:0] c_nxt, f_nxt;
  assign c_nxt = SQ_W'(sx2_r) + SQ_W'(sy2_r) - SQ_W'(sx1_r) - SQ_W'(sy1_r);
  assign f_nxt = SQ_W'(sx3_r) + SQ_W'(sy3_r) - SQ_W'(sx2_r) - SQ_W'(sy2_r);

  logic                    v2_r;
  logic signed [DIF_W-1:0] a2_r, b2_r, d2_r, e2_r;
  logic signed [SQ_W-1:0]  c2_r, f2_r;
  coord_t                  x1_2_r, y1_2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      d2_r   <= d1_r;
      e2_r   <= e1_r;
      c2_r   <= c_nxt;
      f2_r   <= f_nxt;
      x1_2_r <= x1_1_r;
      y1_2_r <= y1_1_r;
    end
  end

  // stage 3: cross products
  logic                    v3_r;
  logic signed [DEN_W-1:0] pbd_r, pea_r;
  logic signed [NUM_W-1:0] pbf_r, pec_r, pdc_r, paf_r;
  coord_t                  x1_3_r, y1_3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pbd_r  <= b2_r * d2_r;
      pea_r  <= e2_r * a2_r;
      pbf_r  <= b2_r * f2_r;
      pec_r  <= e2_r * c2_r;
      pdc_r  <= d2_r * c2_r;
      paf_r  <= a2_r * f2_r;
      x1_3_r <= x1_2_r;
      y1_3_r <= y1_2_r;
    end
  end

  // stage 4: determinant and numerators
  logic                    v4_r;
  logic signed [DET_W-1:0] det_r;
  logic signed [NUM_W-1:0] nx_r, ny_r;
  coord_t                  x1_4_r, y1_4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r  <= DET_W'(pbd_r) - DET_W'(pea_r);
      nx_r   <= pbf_r - pec_r;
      ny_r   <= pdc_r - paf_r;
      x1_4_r <= x1_3_r;
      y1_4_r <= y1_3_r;
    end
  end

  // stage 5: magnitudes and quotient signs
  logic [DET_W-1:0] dabs_nxt;
  logic [NUM_W-1:0] nxm_nxt, nym_nxt;
  logic             deg_nxt;
  assign dabs_nxt = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
  assign nxm_nxt  = nx_r[NUM_W-1] ? NUM_W'(-nx_r) : NUM_W'(nx_r);
  assign nym_nxt  = ny_r[NUM_W-1] ? NUM_W'(-ny_r) : NUM_W'(ny_r);
  assign deg_nxt  = det_r == '0;

  logic             v5_r;
  logic [NUM_W-1:0] nxm_r, nym_r;
  logic [DEN_W-1:0] den_r;
  div_tag_t         dtag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nxm_r        <= nxm_nxt;
      nym_r        <= nym_nxt;
      // a zero divisor is replaced, the quotient is not used then
      den_r        <= deg_nxt ? DEN_W'(1) : dabs_nxt[DEN_W-1:0];
      dtag_r.x1    <= x1_4_r;
      dtag_r.y1    <= y1_4_r;
      dtag_r.neg_x <= nx_r[NUM_W-1] ^ det_r[DET_W-1];
      dtag_r.neg_y <= ny_r[NUM_W-1] ^ det_r[DET_W-1];
      dtag_r.deg   <= deg_nxt;
    end
  end

  logic             dv;
  logic [NUM_W-1:0] qx, qy;
  div_tag_t         dtag;

  crr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v5_r),
    .num_x    (nxm_r),
    .num_y    (nym_r),
    .den      (den_r),
    .in_tag   (dtag_r),
    .out_valid(dv),
    .quo_x    (qx),
    .quo_y    (qy),
    .out_tag  (dtag)
  );

  // post stage 1: signed centre
  logic signed [CX_W-1:0] qxs, qys;
  assign qxs = {1'b0, qx};
  assign qys = {1'b0, qy};

  logic                   p1_v_r;
  logic signed [CX_W-1:0] cx_r, cy_r;
  coord_t                 x1_p1_r, y1_p1_r;
  logic                   deg_p1_r, cr_p1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r     <= dtag.neg_x ? -qxs : qxs;
      cy_r     <= dtag.neg_y ? -qys : qys;
      x1_p1_r  <= dtag.x1;
      y1_p1_r  <= dtag.y1;
      deg_p1_r <= dtag.deg;
      cr_p1_r  <= !dtag.neg_x && (qx != '0);
    end
  end

  // post stage 2: offset from the first point
  logic                   p2_v_r;
  logic signed [DX_W-1:0] dx_r, dy_r;
  logic                   deg_p2_r, cr_p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (en) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r     <= DX_W'(cx_r) - DX_W'(x1_p1_r);
      dy_r     <= DX_W'(cy_r) - DX_W'(y1_p1_r);
      deg_p2_r <= deg_p1_r;
      cr_p2_r  <= cr_p1_r;
    end
  end

  // post stage 3: absolute offsets
  logic              p3_v_r;
  logic [DX_W-1:0]   adx_r, ady_r;
  logic              deg_p3_r, cr_p3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (en) begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adx_r    <= dx_r[DX_W-1] ? DX_W'(-dx_r) : DX_W'(dx_r);
      ady_r    <= dy_r[DX_W-1] ? DX_W'(-dy_r) : DX_W'(dy_r);
      deg_p3_r <= deg_p2_r;
      cr_p3_r  <= cr_p2_r;
    end
  end

  // post stage 4: range check and squares
  logic               p4_v_r;
  logic [2*LIM_W-1:0] sqx_r, sqy_r;
  logic               far_p4_r, deg_p4_r, cr_p4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_v_r <= 1'b0;
    end else if (en) begin
      p4_v_r <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r    <= adx_r[LIM_W-1:0] * adx_r[LIM_W-1:0];
      sqy_r    <= ady_r[LIM_W-1:0] * ady_r[LIM_W-1:0];
      far_p4_r <= (adx_r > DX_W'(RMAX)) || (ady_r > DX_W'(RMAX));
      deg_p4_r <= deg_p3_r;
      cr_p4_r  <= cr_p3_r;
    end
  end

  // post stage 5: squared distance
  logic          p5_v_r;
  logic [SW-1:0] dist_r;
  sq_tag_t       stag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_v_r <= 1'b0;
    end else if (en) begin
      p5_v_r <= p4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r        <= SW'(sqx_r) + SW'(sqy_r);
      stag_r.far    <= far_p4_r;
      stag_r.deg    <= deg_p4_r;
      stag_r.cright <= cr_p4_r;
    end
  end

  logic            sv;
  logic [RT_W-1:0] rt;
  sq_tag_t         stag;

  crr_sqrt #(
    .SW(SW)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (p5_v_r),
    .value    (dist_r),
    .in_tag   (stag_r),
    .out_valid(sv),
    .root     (rt),
    .out_tag  (stag)
  );

  // clamp and output register
  logic [LIM_W-1:0]       rcl;
  logic [LIM_W+RAD_W-1:0] rext;
  always_comb begin
    if (stag.deg || stag.far || (rt > RT_W'(RMAX))) begin
      rcl = LIM_W'(RMAX);
    end else if (rt < RT_W'(RMIN)) begin
      rcl = LIM_W'(RMIN);
    end else begin
      rcl = rt[LIM_W-1:0];
    end
  end
  assign rext = {RAD_W'(0), rcl};

  logic             out_v_r;
  logic [RAD_W-1:0] rad_r;
  logic             cr_r, deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= rext[RAD_W-1:0];
      cr_r  <= stag.cright && !stag.deg;
      deg_r <= stag.deg;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, cr_r, rad_r};
  assign out_tuser  = deg_r;

endmodule
`default_nettype wire

>>> design/crr_div.sv
// pipelined restoring divider, two dividends over one shared divisor, one quotient bit a stage
`default_nettype none
module crr_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [crr_pkg::NUM_W-1:0] num_x,
  input  wire logic [crr_pkg::NUM_W-1:0] num_y,
  input  wire logic [crr_pkg::DEN_W-1:0] den,
  input  wire crr_pkg::div_tag_t         in_tag,
  output logic                           out_valid,
  output logic [crr_pkg::NUM_W-1:0]      quo_x,
  output logic [crr_pkg::NUM_W-1:0]      quo_y,
  output crr_pkg::div_tag_t              out_tag
);
  import crr_pkg::*;

  logic [NUM_W-1:0] vld_r;
  logic [DEN_W-1:0] remx_r [NUM_W];
  logic [DEN_W-1:0] remy_r [NUM_W];
  logic [NUM_W-1:0] qx_r   [NUM_W];
  logic [NUM_W-1:0] qy_r   [NUM_W];
  logic [DEN_W-1:0] den_r  [NUM_W];
  div_tag_t         tag_r  [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic             v_in;
    logic [DEN_W-1:0] rx_in, ry_in, d_in;
    logic [NUM_W-1:0] qx_in, qy_in;
    div_tag_t         t_in;
    logic [DEN_W:0]   tx, ty, sx, sy;
    logic             gx, gy;

    if (i == 0) begin : g_first
      assign v_in  = in_valid;
      assign rx_in = '0;
      assign ry_in = '0;
      assign qx_in = num_x;
      assign qy_in = num_y;
      assign d_in  = den;
      assign t_in  = in_tag;
    end else begin : g_next
      assign v_in  = vld_r[i-1];
      assign rx_in = remx_r[i-1];
      assign ry_in = remy_r[i-1];
      assign qx_in = qx_r[i-1];
      assign qy_in = qy_r[i-1];
      assign d_in  = den_r[i-1];
      assign t_in  = tag_r[i-1];
    end

    // shift in the next dividend bit and try the divisor
    assign tx = {rx_in, qx_in[NUM_W-1]};
    assign ty = {ry_in, qy_in[NUM_W-1]};
    assign sx = tx - {1'b0, d_in};
    assign sy = ty - {1'b0, d_in};
    assign gx = tx >= {1'b0, d_in};
    assign gy = ty >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        remx_r[i] <= gx ? sx[DEN_W-1:0] : tx[DEN_W-1:0];
        remy_r[i] <= gy ? sy[DEN_W-1:0] : ty[DEN_W-1:0];
        qx_r[i]   <= {qx_in[NUM_W-2:0], gx};
        qy_r[i]   <= {qy_in[NUM_W-2:0], gy};
        den_r[i]  <= d_in;
        tag_r[i]  <= t_in;
      end
    end
  end

  assign out_valid = vld_r[NUM_W-1];
  assign quo_x     = qx_r[NUM_W-1];
  assign quo_y     = qy_r[NUM_W-1];
  assign out_tag   = tag_r[NUM_W-1];

endmodule
`default_nettype wire

>>> design/crr_sqrt.sv
// pipelined integer square root, one root bit a stage, floor result
`default_nettype none
module crr_sqrt #(
  parameter int SW = 44
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [SW-1:0]     value,
  input  wire crr_pkg::sq_tag_t  in_tag,
  output logic                   out_valid,
  output logic [SW/2-1:0]        root,
  output crr_pkg::sq_tag_t       out_tag
);
  import crr_pkg::*;

  localparam int RW = SW / 2;

  logic [RW-1:0] vld_r;
  logic [RW:0]   rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [SW-1:0] val_r  [RW];
  sq_tag_t       tag_r  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic          v_in;
    logic [RW:0]   r_in;
    logic [RW-1:0] q_in;
    logic [SW-1:0] s_in;
    sq_tag_t       t_in;
    logic [RW+2:0] cand, trial, diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = '0;
      assign q_in = '0;
      assign s_in = value;
      assign t_in = in_tag;
    end else begin : g_next
      assign v_in = vld_r[i-1];
      assign r_in = rem_r[i-1];
      assign q_in = root_r[i-1];
      assign s_in = val_r[i-1];
      assign t_in = tag_r[i-1];
    end

    assign cand  = {r_in, s_in[SW-1:SW-2]};
    assign trial = {1'b0, q_in, 2'b01};
    assign diff  = cand - trial;
    assign ge    = cand >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? diff[RW:0] : cand[RW:0];
        root_r[i] <= {q_in[RW-2:0], ge};
        val_r[i]  <= {s_in[SW-3:0], 2'b00};
        tag_r[i]  <= t_in;
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign root      = root_r[RW-1];
  assign out_tag   = tag_r[RW-1];

endmodule
`default_nettype wire

>>> design/crr_chk.sv
// port-level checks for the circumcircle radius block, bound to the top level
`default_nettype none
module crr_chk #(
  parameter int FRAC_BITS = 8
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [crr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [0:0]                      out_tuser
);
  import crr_pkg::*;

  localparam int RMAX = 5000 << FRAC_BITS;
  localparam int RMIN = 1 << FRAC_BITS;
  localparam logic [RAD_W-1:0] RMAX_M = RAD_W'(RMAX);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // the pipeline takes input exactly when the output stage can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  // collinear points give the far radius and no centre side
  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[RAD_W-1:0] == RMAX_M && !out_tdata[RAD_W])
    else $error("degenerate result malformed");

  // radius stays inside the clamp range where it fits the field
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (RMAX < (1 << RAD_W)) |->
      out_tdata[RAD_W-1:0] >= RAD_W'(RMIN) && out_tdata[RAD_W-1:0] <= RMAX_M)
    else $error("radius outside clamp range");

  // no result appears out of an empty pipeline right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind circumcircle_radius_top crr_chk #(.FRAC_BITS(FRAC_BITS)) u_crr_chk (.*);
`default_nettype wire
